// ===== rtl/core/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int unsigned CfgIndexW = 3;

  localparam logic [CfgIndexW-1:0] RegKp     = 3'd0;
  localparam logic [CfgIndexW-1:0] RegKi     = 3'd1;
  localparam logic [CfgIndexW-1:0] RegKd     = 3'd2;
  localparam logic [CfgIndexW-1:0] RegOutLim = 3'd3;
  localparam logic [CfgIndexW-1:0] RegIntLim = 3'd4;

  localparam logic FuncUpdate = 1'b0;
  localparam logic FuncReset  = 1'b1;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLEAR,
    DP_SKIP,
    DP_ERR,
    DP_MUL_ED,
    DP_INTEG,
    DP_MUL_P,
    DP_MUL_I,
    DP_MUL_D,
    DP_ACC,
    DP_DERIV,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_ED,
    ST_INTEG,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_I,
    ST_ACC_I,
    ST_WAIT_DIV,
    ST_MUL_D,
    ST_ACC_D,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic dt_zero;
    logic div_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/pidc_ctrl.sv =====
`timescale 1ns / 1ps

module pidc_ctrl import pidc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_set;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NONE;
    out_set   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.func == FuncReset) begin
          if (out_free) begin
            cmd_o.op = DP_CLEAR;
            out_set  = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (sts_i.dt_zero) begin
          if (out_free) begin
            cmd_o.op = DP_SKIP;
            out_set  = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          cmd_o.op = DP_ERR;
          state_d  = ST_MUL_ED;
        end
      end
      ST_MUL_ED: begin
        cmd_o.op = DP_MUL_ED;
        state_d  = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.op = DP_INTEG;
        state_d  = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.op = DP_MUL_P;
        state_d  = ST_ACC_P;
      end
      ST_ACC_P: begin
        cmd_o.op = DP_ACC;
        state_d  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd_o.op = DP_MUL_I;
        state_d  = ST_ACC_I;
      end
      ST_ACC_I: begin
        cmd_o.op = DP_ACC;
        state_d  = ST_WAIT_DIV;
      end
      ST_WAIT_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = DP_DERIV;
          state_d  = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        cmd_o.op = DP_MUL_D;
        state_d  = ST_ACC_D;
      end
      ST_ACC_D: begin
        cmd_o.op = DP_ACC;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.op = DP_FINISH;
          out_set  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_set) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/pidc_dpath.sv =====
`timescale 1ns / 1ps

module pidc_dpath import pidc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           sts_o,
  input  logic                 func_i,
  input  logic signed [31:0]   target_i,
  input  logic signed [31:0]   actual_i,
  input  logic [15:0]          dt_i,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic signed [31:0]   drive_o,
  output logic                 skipped_o
);

  localparam logic [5:0] DivSteps = 6'd48;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic fits;
    fits = (&v[47:31]) || !(|v[47:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[47]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] vx;
    logic signed [32:0] lx;
    logic signed [32:0] nx;
    vx = {v[31], v};
    lx = {2'b00, lim};
    nx = -lx;
    if (vx > lx) begin
      return {1'b0, lim};
    end else if (vx < nx) begin
      return nx[31:0];
    end else begin
      return v;
    end
  endfunction

  // configuration
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic [30:0]        out_lim_q, int_lim_q;

  // item and working registers
  logic               func_q;
  logic signed [31:0] tgt_q, act_q;
  logic [15:0]        dt_q;
  logic signed [31:0] err_q, integ_q, deriv_q;
  logic signed [63:0] prod_q;
  logic signed [33:0] sum_q;
  logic signed [31:0] acc_q, prev_q;
  logic signed [31:0] drive_q;
  logic               skipped_q;

  // divider
  logic [47:0] div_num_q;
  logic [15:0] div_rem_q;
  logic [5:0]  div_cnt_q;
  logic        div_busy_q;
  logic        div_neg_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [47:0] term;
  logic signed [31:0] term_sat;
  logic signed [32:0] err_diff;
  logic signed [32:0] integ_sum;
  logic signed [32:0] dev;
  logic [32:0]        dev_mag;
  logic [16:0]        div_shift;
  logic [17:0]        div_diff;
  logic               div_ge;
  logic [47:0]        quo;
  logic [31:0]        quo_neg;
  logic signed [31:0] deriv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      out_lim_q <= '1;
      int_lim_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegKp:     kp_q      <= cfg_data_i;
        RegKi:     ki_q      <= cfg_data_i;
        RegKd:     kd_q      <= cfg_data_i;
        RegOutLim: out_lim_q <= cfg_data_i[30:0];
        RegIntLim: int_lim_q <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = kp_q;
    mul_b = err_q;
    case (cmd_i.op)
      DP_MUL_ED: begin
        mul_a = err_q;
        mul_b = {16'h0000, dt_q};
      end
      DP_MUL_I: begin
        mul_a = ki_q;
        mul_b = integ_q;
      end
      DP_MUL_D: begin
        mul_a = kd_q;
        mul_b = deriv_q;
      end
      default: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign term      = $signed(prod_q[63:16]);
  assign term_sat  = sat48(term);
  assign err_diff  = {tgt_q[31], tgt_q} - {act_q[31], act_q};
  assign integ_sum = {acc_q[31], acc_q} + {term[31], term[31:0]};
  assign dev       = {err_q[31], err_q} - {prev_q[31], prev_q};
  assign dev_mag   = dev[32] ? -dev : dev;

  assign div_shift = {div_rem_q, div_num_q[47]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, dt_q};
  assign div_ge    = !div_diff[17];

  assign quo     = div_num_q;
  assign quo_neg = -quo[31:0];

  always_comb begin
    if (!div_neg_q) begin
      deriv_d = (|quo[47:31]) ? 32'sh7FFF_FFFF : quo[31:0];
    end else if ((|quo[47:32]) || (quo[31] && (|quo[30:0]))) begin
      deriv_d = 32'sh8000_0000;
    end else begin
      deriv_d = quo_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      prev_q     <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      case (cmd_i.op)
        DP_CLEAR: begin
          acc_q  <= '0;
          prev_q <= '0;
        end
        DP_FINISH: begin
          acc_q  <= clamp_sym(integ_q, int_lim_q);
          prev_q <= err_q;
        end
        default: begin
        end
      endcase
      if (cmd_i.op == DP_INTEG) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= DivSteps;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd1) begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        func_q <= func_i;
        tgt_q  <= target_i;
        act_q  <= actual_i;
        dt_q   <= dt_i;
      end
      DP_CLEAR: begin
        drive_q   <= '0;
        skipped_q <= 1'b0;
      end
      DP_SKIP: begin
        drive_q   <= '0;
        skipped_q <= 1'b1;
      end
      DP_ERR: begin
        err_q <= sat48({{15{err_diff[32]}}, err_diff});
        sum_q <= '0;
      end
      DP_MUL_ED, DP_MUL_P, DP_MUL_I, DP_MUL_D: begin
        prod_q <= mul_p;
      end
      DP_INTEG: begin
        integ_q <= sat48({{15{integ_sum[32]}}, integ_sum});
      end
      DP_ACC: begin
        sum_q <= sum_q + {{2{term_sat[31]}}, term_sat};
      end
      DP_DERIV: begin
        deriv_q <= deriv_d;
      end
      DP_FINISH: begin
        drive_q   <= clamp_sym(sat48({{14{sum_q[33]}}, sum_q}), out_lim_q);
        skipped_q <= 1'b0;
      end
      default: begin
      end
    endcase
    // restoring divide of |error delta| * 2^16 by dt, one quotient bit per cycle
    if (cmd_i.op == DP_INTEG) begin
      div_num_q <= {dev_mag[31:0], 16'h0000};
      div_rem_q <= '0;
      div_neg_q <= dev[32];
    end else if (div_busy_q) begin
      div_num_q <= {div_num_q[46:0], div_ge};
      div_rem_q <= div_ge ? div_diff[15:0] : div_shift[15:0];
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.dt_zero  = (dt_q == '0);
  assign sts_o.div_busy = div_busy_q;

  assign drive_o   = drive_q;
  assign skipped_o = skipped_q;

endmodule

// ===== rtl/core/pid_controller_step.sv =====
`timescale 1ns / 1ps
// fixed-point pid step, signed q16.16, dt unsigned q0.16
// input channel: in_valid_i / in_stall_o with func_i, target_i, actual_i, dt_i;
//   a word is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i with drive_o, skipped_o
// config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects kp, ki, kd,
//   output limit or integral limit; ready is always high, write only when idle
// one item at a time: in_stall_o is high from acceptance until the result
//   is loaded into the output register
// reset and zero-dt words load their result from the decode state once the output
//   register is free, and the controller then returns to idle for the next word
// an update word passes decode, the error*dt product, the integral, the proportional and
//   integral products, a wait for the divider, the derivative product and finish; the
//   48-step serial divider that forms the derivative sets its pace, and the shared 32x32
//   multiplier runs the proportional and integral products while the divider works
// a result waiting in the output register does not block the next accept;
//   the next result waits until the held word is taken
// while the receiver stalls, out_valid_o and the result word hold
// reset clears gains, sets both limits to full scale and clears the integral
//   and the previous error; no result is pending after reset

module pid_controller_step import pidc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic signed [31:0]   target_i,
  input  logic signed [31:0]   actual_i,
  input  logic [15:0]          dt_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   drive_o,
  output logic                 skipped_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pidc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .target_i    (target_i),
    .actual_i    (actual_i),
    .dt_i        (dt_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .drive_o     (drive_o),
    .skipped_o   (skipped_o)
  );

endmodule

// ===== rtl/core/pidc_checker.sv =====
`timescale 1ns / 1ps

module pidc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [31:0]   drive_o,
  input logic                 skipped_o
);

  // held result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) && $stable(skipped_o))
    else $error("result word changed while stalled");

  // one word in flight: accept closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // a skipped step drives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skipped_o |-> drive_o == 32'sd0)
    else $error("skipped step with nonzero drive");

  // a new result only appears at the end of work on an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in flight");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (.*);

// ===== dv/pid_step_checker.sv =====
`timescale 1ns / 1ps

module pid_step_checker import pidc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 func_i,
  input  logic signed [31:0]   target_i,
  input  logic signed [31:0]   actual_i,
  input  logic [15:0]          dt_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [31:0]   drive_i,
  input  logic                 skipped_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o
);

  typedef struct packed {
    logic signed [31:0] drive;
    logic               skipped;
  } drive_word_t;

  localparam longint WordMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WordMin = -64'sh0000_0000_8000_0000;

  longint kp = 0;
  longint ki = 0;
  longint kd = 0;
  longint out_lim = WordMax;
  longint int_lim = WordMax;
  longint integ_acc = 0;
  longint last_err = 0;

  drive_word_t drive_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  function automatic longint sat_word(longint v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // q16.16 product, floored, saturated
  function automatic longint gain_product(longint gain, longint x);
    return sat_word((gain * x) >>> 16);
  endfunction

  function automatic drive_word_t predict_step(logic f, logic signed [31:0] tgt,
                                               logic signed [31:0] act, logic [15:0] dt);
    drive_word_t w;
    longint      err;
    longint      integ;
    longint      slope;
    longint      total;
    longint      dt_l;
    w.drive   = '0;
    w.skipped = 1'b0;
    if (f == FuncReset) begin
      integ_acc = 0;
      last_err  = 0;
      return w;
    end
    if (dt == '0) begin
      w.skipped = 1'b1;
      return w;
    end
    dt_l  = longint'(dt);
    err   = sat_word(longint'(tgt) - longint'(act));
    integ = sat_word(integ_acc + ((err * dt_l) >>> 16));
    slope = sat_word(((err - last_err) * 64'sd65536) / dt_l);
    total = gain_product(kp, err) + gain_product(ki, integ) + gain_product(kd, slope);
    w.drive   = 32'(clamp_mag(sat_word(total), out_lim));
    integ_acc = clamp_mag(integ, int_lim);
    last_err  = err;
    return w;
  endfunction

  task automatic check_word(logic signed [31:0] drive, logic skipped);
    drive_word_t exp_w;
    if (drive_expect_q.size() == 0) begin
      $error("unexpected output word: drive %0d skipped %0d", drive, skipped);
      mismatches++;
    end else begin
      exp_w = drive_expect_q.pop_front();
      if (drive !== exp_w.drive) begin
        $error("drive: expected %0d, actual %0d", exp_w.drive, drive);
        mismatches++;
      end
      if (skipped !== exp_w.skipped) begin
        $error("skipped: expected %0d, actual %0d", exp_w.skipped, skipped);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp        = 0;
      ki        = 0;
      kd        = 0;
      out_lim   = WordMax;
      int_lim   = WordMax;
      integ_acc = 0;
      last_err  = 0;
      drive_expect_q.delete();
      outstanding = 0;
    end else begin
      // retire before push so a word never matches its own prediction
      if (out_valid_i && !out_stall_i) begin
        check_word(drive_i, skipped_i);
      end
      if (in_valid_i && !in_stall_i) begin
        drive_expect_q.push_back(predict_step(func_i, target_i, actual_i, dt_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegKp:     kp = longint'($signed(cfg_data_i));
          RegKi:     ki = longint'($signed(cfg_data_i));
          RegKd:     kd = longint'($signed(cfg_data_i));
          RegOutLim: out_lim = longint'({1'b0, cfg_data_i[30:0]});
          RegIntLim: int_lim = longint'({1'b0, cfg_data_i[30:0]});
          default: ;
        endcase
      end
      outstanding = drive_expect_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pidc_pkg::*;

  localparam logic [CfgIndexW-1:0] RegFirstUnused = RegIntLim + 1'b1;
  localparam logic [CfgIndexW-1:0] RegLastUnused  = '1;
  localparam int unsigned          PhaseItems     = 275;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 func_i = FuncUpdate;
  logic signed [31:0]   target_i = '0;
  logic signed [31:0]   actual_i = '0;
  logic [15:0]          dt_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [31:0]   drive_o;
  logic                 skipped_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = RegKp;
  logic [31:0]          cfg_data_i = '0;

  int unsigned mismatch_count;
  int unsigned outstanding;
  logic        steady = 1'b0;
  logic [31:0] setpoint = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pid_controller_step u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .target_i    (target_i),
    .actual_i    (actual_i),
    .dt_i        (dt_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .skipped_o   (skipped_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pid_step_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .target_i         (target_i),
    .actual_i         (actual_i),
    .dt_i             (dt_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_i          (drive_o),
    .skipped_i        (skipped_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 26);
  end

  task automatic send_word(logic f, logic [31:0] tgt, logic [31:0] act, logic [15:0] dt);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 26) gap = $urandom_range(1, 80);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    target_i   <= tgt;
    actual_i   <= act;
    dt_i       <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                logic [31:0] out_lim, logic [31:0] int_lim);
    cfg_write(RegKp, kp);
    cfg_write(RegKi, ki);
    cfg_write(RegKd, kd);
    cfg_write(RegOutLim, out_lim);
    cfg_write(RegIntLim, int_lim);
    // unused index, must be ignored
    cfg_write(CfgIndexW'($urandom_range(RegFirstUnused, RegLastUnused)), $urandom);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain(logic wide);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return pick_extreme();
    if (wide || r < 40) return $urandom;
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [31:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(32'h0000_1000, 32'h00FF_FFFF);
    if (r < 75) return $urandom;
    return pick_extreme();
  endfunction

  task automatic send_random_word();
    logic        f;
    logic [31:0] tgt;
    logic [31:0] act;
    logic [15:0] dt;
    int unsigned r;
    f = ($urandom_range(99) < 4) ? FuncReset : FuncUpdate;
    r = $urandom_range(99);
    if (r < 5) setpoint = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    if (r < 70) begin
      tgt = setpoint;
      act = setpoint + ($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
    end else if (r < 90) begin
      tgt = $urandom;
      act = $urandom;
    end else begin
      tgt = pick_extreme();
      act = pick_extreme();
    end
    r = $urandom_range(99);
    if (r < 5) dt = '0;
    else if (r < 12) dt = ($urandom_range(1) == 0) ? 16'h0001 : 16'hFFFF;
    else if (r < 70) dt = $urandom_range(1, 16'h2000);
    else dt = $urandom;
    send_word(f, tgt, act, dt);
  endtask

  initial begin
    #10_000_000;
    $display("[pid_controller_step] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // settings out of reset: gains zero
    send_word(FuncUpdate, 32'h0002_0000, 32'h0001_0000, 16'h1000);
    send_word(FuncUpdate, 32'h0005_0000, 32'h0001_0000, 16'h0000);
    drain();

    write_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_0100,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    cfg_write(RegFirstUnused, 32'hFFFF_FFFF);
    cfg_write(RegLastUnused, 32'h1234_5678);
    send_word(FuncUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_word(FuncUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001);
    send_word(FuncReset, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
    send_word(FuncUpdate, 32'h0003_0000, 32'h0001_0000, 16'h0000);
    send_word(FuncUpdate, 32'h1234_5678, 32'h1234_5678, 16'h8000);
    for (k = 0; k < 4; k++) begin
      send_word(FuncUpdate, 32'h0002_0000, 32'h0001_0000, 16'h0100);
    end
    send_word(FuncUpdate, 32'hFFFF_0000, 32'h0000_0001, 16'h0001);
    drain();

    write_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h0000_0000, 32'h0000_0000);
    send_word(FuncUpdate, 32'h0010_0000, 32'h0000_0000, 16'h0040);
    send_word(FuncUpdate, 32'h8000_0000, 32'h0000_0001, 16'hFFFF);
    send_word(FuncUpdate, 32'h0000_0000, 32'h0100_0000, 16'h0001);
    drain();

    // bit 31 of the limit words is dropped
    write_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'h8001_0000);
    for (k = 0; k < 5; k++) begin
      send_word(FuncUpdate, 32'h0004_0000, 32'h0000_0000, 16'h4000);
    end
    send_word(FuncReset, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
    drain();

    for (int unsigned phase = 0; phase < 6; phase++) begin
      write_settings(pick_gain(phase == 5), pick_gain(phase == 5), pick_gain(phase == 5),
                     pick_limit(), pick_limit());
      @(posedge clk_i);
      steady = (phase == 2);
      for (k = 0; k < PhaseItems; k++) begin
        if (k == PhaseItems / 2) drain();
        send_random_word();
      end
      drain();
      @(posedge clk_i);
      steady = 1'b0;
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[pid_controller_step] OK");
    end else begin
      $display("[pid_controller_step] ERROR");
    end
    $finish;
  end

endmodule
